// ===== src/pof_pkg.sv =====
// ----------------------------------------------------------------------------
// pof_pkg
// Shared widths, constants and the pipeline tag for the pitch word encoder.
// ----------------------------------------------------------------------------
package pof_pkg;

    localparam int RATE_W  = 20;                 // source sample rate
    localparam int SCALE_W = 24;                 // Q16 pitch scale
    localparam int NAT_W   = 16;                 // native engine rate
    localparam int PROD_W  = RATE_W + SCALE_W;   // rate * scale
    localparam int NUM_W   = PROD_W + 8;         // product pre-shifted by 2^8
    localparam int REM_W   = 48;                 // divisor / remainder width
    localparam int SHF_W   = 4;                  // biased octave, 0..15
    localparam int OCT_W   = 4;
    localparam int FRAC_W  = 10;
    localparam int QUO_W   = FRAC_W + 1;         // quotient with round bit
    localparam int WORD_W  = 15;

    localparam logic [NAT_W-1:0]  NATIVE_RESET = 16'd44100;
    localparam logic [FRAC_W-1:0] FRAC_MAX     = 10'd1023;
    localparam logic [SHF_W-1:0]  OCT_BIAS     = 4'b1000;

    // Control that travels alongside each request.
    typedef struct packed {
        logic             vld;   // stage holds a request
        logic             zero;  // rate or scale was zero
        logic [SHF_W-1:0] shift; // octave + 8
        logic             sat;   // normalized ratio >= 2.0
        logic             pos;   // normalized ratio > 1.0
    } t_tag;

endpackage

// ===== src/pof_norm.sv =====
// ----------------------------------------------------------------------------
// pof_norm
// Octave search: four compare stages pick the octave bit by bit, then a
// prep stage forms the divider operands and the range flags.
// ----------------------------------------------------------------------------
module pof_norm
    import pof_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tag             i_tag,
    input  logic [NUM_W-1:0] i_num,
    input  logic [NUM_W-1:0] i_den,
    output t_tag             o_tag,
    output logic [REM_W-1:0] o_rem,
    output logic [REM_W-1:0] o_div
);

    localparam int STEPS = SHF_W;

    t_tag             w_tag [0:STEPS];
    logic [NUM_W-1:0] w_num [0:STEPS];
    logic [NUM_W-1:0] w_den [0:STEPS];

    assign w_tag[0] = i_tag;
    assign w_num[0] = i_num;
    assign w_den[0] = i_den;

    // Step g decides octave bit (STEPS-1-g): try doubling the divisor 2^bit times.
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam int BIT = STEPS - 1 - g;
        localparam int SH  = 1 << BIT;

        t_tag             r_tag;
        logic [NUM_W-1:0] r_num;
        logic [NUM_W-1:0] r_den;
        t_tag             n_tag;
        logic [NUM_W-1:0] n_den;
        logic [NUM_W-1:0] n_cand;

        always_comb begin
            n_cand = w_den[g] << SH;
            n_tag  = w_tag[g];
            n_den  = w_den[g];
            if (w_num[g] >= n_cand) begin
                n_den            = n_cand;
                n_tag.shift[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag <= '0;
            end else begin
                r_tag <= n_tag;
            end
        end

        always_ff @(posedge i_clk) begin
            r_num <= w_num[g];
            r_den <= n_den;
        end

        assign w_tag[g+1] = r_tag;
        assign w_num[g+1] = r_num;
        assign w_den[g+1] = r_den;
    end

    // Prep: ratio A/B is now in [1,2) unless clamped at either end.
    t_tag             r_tag;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_div;
    t_tag             n_tag;
    logic [NUM_W-1:0] n_diff;

    always_comb begin
        n_tag     = w_tag[STEPS];
        n_tag.pos = w_num[STEPS] > w_den[STEPS];
        n_tag.sat = w_num[STEPS] >= (w_den[STEPS] << 1);
        n_diff    = w_num[STEPS] - w_den[STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= n_tag;
        end
    end

    // diff < den < 2^47 whenever the quotient is used
    always_ff @(posedge i_clk) begin
        r_rem <= n_diff[REM_W-1:0];
        r_div <= w_den[STEPS][REM_W-1:0];
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_div = r_div;

endmodule

// ===== src/pof_div.sv =====
// ----------------------------------------------------------------------------
// pof_div
// Pipelined restoring divider: one quotient bit per stage, QUO_W stages.
// ----------------------------------------------------------------------------
module pof_div
    import pof_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tag             i_tag,
    input  logic [REM_W-1:0] i_rem,
    input  logic [REM_W-1:0] i_div,
    output t_tag             o_tag,
    output logic [QUO_W-1:0] o_quo
);

    t_tag             w_tag [0:QUO_W];
    logic [REM_W-1:0] w_rem [0:QUO_W];
    logic [REM_W-1:0] w_div [0:QUO_W];
    logic [QUO_W-1:0] w_quo [0:QUO_W];

    assign w_tag[0] = i_tag;
    assign w_rem[0] = i_rem;
    assign w_div[0] = i_div;
    assign w_quo[0] = '0;

    for (genvar g = 0; g < QUO_W; g++) begin : g_bit
        t_tag             r_tag;
        logic [REM_W-1:0] r_rem;
        logic [REM_W-1:0] r_div;
        logic [QUO_W-1:0] r_quo;
        logic [REM_W-1:0] n_two;
        logic [REM_W-1:0] n_rem;
        logic             n_ge;

        always_comb begin
            n_two = {w_rem[g][REM_W-2:0], 1'b0};
            n_ge  = n_two >= w_div[g];
            n_rem = n_ge ? (n_two - w_div[g]) : n_two;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag <= '0;
            end else begin
                r_tag <= w_tag[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem <= n_rem;
            r_div <= w_div[g];
            r_quo <= {w_quo[g][QUO_W-2:0], n_ge};
        end

        assign w_tag[g+1] = r_tag;
        assign w_rem[g+1] = r_rem;
        assign w_div[g+1] = r_div;
        assign w_quo[g+1] = r_quo;
    end

    assign o_tag = w_tag[QUO_W];
    assign o_quo = w_quo[QUO_W];

endmodule

// ===== src/pitch_octave_fraction_encoder.sv =====
// ----------------------------------------------------------------------------
// pitch_octave_fraction_encoder
// Encodes sample rate * Q16 pitch scale against the native engine rate into
// an octave / 10-bit fraction pitch word.
// ----------------------------------------------------------------------------
// Pipeline: 18 register stages, from the product register to the output register.
// Throughput: one request per cycle; busy never rises. Depth is the product stage, the
//   4-step octave search with its prep stage, the 11-step quotient pipeline and the output stage.
// Reset: clears all pipeline valid bits and loads native_rate = 44100.
// Each result is shown for one cycle only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module pitch_octave_fraction_encoder
    import pof_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     start,
    output logic                     busy,
    input  logic [RATE_W-1:0]        i_sample_rate,
    input  logic [SCALE_W-1:0]       i_pitch_scale,
    // native rate register write
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [NAT_W-1:0]         i_cfg_data,
    // result
    output logic                     o_valid,
    output logic signed [OCT_W-1:0]  o_octave,
    output logic [FRAC_W-1:0]        o_fraction,
    output logic [WORD_W-1:0]        o_pitch_word
);

    // Full-rate pipeline: never holds requests off.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic w_accept;
    assign w_accept = start && !busy;

    // ---------------- native rate register ----------------
    logic [NAT_W-1:0] r_native;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_native <= NATIVE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_native <= i_cfg_data;
        end
    end

    // ---------------- stage 1: product ----------------
    // Numerator is pre-scaled by 2^8 so octave -8 maps to shift 0 and the
    // search only ever scales the denominator up.
    t_tag             r_s1_tag;
    t_tag             n_s1_tag;
    logic [NUM_W-1:0] r_s1_num;
    logic [NUM_W-1:0] r_s1_den;
    logic [PROD_W-1:0] n_prod;

    assign n_prod = PROD_W'(i_sample_rate) * PROD_W'(i_pitch_scale);

    always_comb begin
        n_s1_tag      = '0;
        n_s1_tag.vld  = w_accept;
        n_s1_tag.zero = (i_sample_rate == '0) || (i_pitch_scale == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
        end else begin
            r_s1_tag <= n_s1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_num <= {n_prod, 8'b0};
        r_s1_den <= NUM_W'({r_native, 16'b0});
    end

    // ---------------- stages 2..6: octave search ----------------
    // A zero native rate compares as zero, so the search runs to the top
    // octave and the ratio flags force a saturated fraction on their own.
    t_tag             w_ntag;
    logic [REM_W-1:0] w_nrem;
    logic [REM_W-1:0] w_ndiv;

    pof_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s1_tag),
        .i_num   (r_s1_num),
        .i_den   (r_s1_den),
        .o_tag   (w_ntag),
        .o_rem   (w_nrem),
        .o_div   (w_ndiv)
    );

    // ---------------- stages 7..17: fraction quotient ----------------
    // floor((A-B) * 2^11 / B); the extra bit is the rounding bit.
    t_tag             w_dtag;
    logic [QUO_W-1:0] w_quo;

    pof_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_ntag),
        .i_rem   (w_nrem),
        .i_div   (w_ndiv),
        .o_tag   (w_dtag),
        .o_quo   (w_quo)
    );

    // ---------------- stage 18: round, saturate, pack ----------------
    logic                    r_valid;
    logic [OCT_W-1:0]        r_oct;
    logic [FRAC_W-1:0]       r_frac;
    logic [QUO_W:0]          n_rnd;
    logic [FRAC_W-1:0]       n_frac;
    logic [OCT_W-1:0]        n_oct;

    always_comb begin
        // round half up: (q + 1) >> 1, 1024 clips to 1023
        n_rnd = {1'b0, w_quo} + {{QUO_W{1'b0}}, 1'b1};
        if (w_dtag.zero) begin
            n_frac = '0;
        end else if (w_dtag.sat) begin
            n_frac = FRAC_MAX;         // clamped at top octave
        end else if (!w_dtag.pos) begin
            n_frac = '0;               // exactly 1.0, or below 1.0 at bottom
        end else if (n_rnd[QUO_W]) begin
            n_frac = FRAC_MAX;         // rounded up to 2.0
        end else begin
            n_frac = n_rnd[FRAC_W:1];
        end
        // shift is octave + 8: flipping the top bit gives two's complement
        n_oct = w_dtag.zero ? '0 : (w_dtag.shift ^ OCT_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_dtag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oct  <= n_oct;
        r_frac <= n_frac;
    end

    assign o_valid      = r_valid;
    assign o_octave     = r_oct;
    assign o_fraction   = r_frac;
    assign o_pitch_word = {r_oct, 1'b0, r_frac};

    // ---------------- assertions ----------------
    // Below the top octave the search must leave the ratio under 2.0.
    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ntag.vld && !w_ntag.zero && (w_ntag.shift != {SHF_W{1'b1}}))
            |-> !w_ntag.sat)
        else $error("octave search left ratio at or above 2.0");

    // A saturated ratio is necessarily above 1.0 for nonzero input.
    a_sat_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ntag.vld && !w_ntag.zero && w_ntag.sat) |-> w_ntag.pos)
        else $error("saturated ratio flagged as not above one");

    // Zero input leaves an all-zero word.
    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dtag.vld && w_dtag.zero) |=> (o_valid && (o_pitch_word == '0)))
        else $error("zero input produced a nonzero pitch word");

endmodule

// ===== tb/sv/pitch_octave_fraction_encoder_test.sv =====
// ----------------------------------------------------------------------------
// pitch_octave_fraction_encoder_test
// Self-checking bench for the octave / fraction pitch encoder. Requests go in
// bursts with random gaps. A scoreboard predicts each pitch word from its own
// copy of the native rate register. Every strobed result is checked against
// the oldest prediction. The run sweeps several native rates, zero included.
// ----------------------------------------------------------------------------
module pitch_octave_fraction_encoder_test;
    import pof_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 9;
    localparam int LATENCY       = 18;      // accept edge to result strobe
    localparam int ITEMS_PHASE   = 190;     // random requests per native rate
    localparam int CYCLE_LIMIT   = 200000;  // watchdog limit
    localparam int OCTAVE_MIN    = -8;
    localparam int OCTAVE_MAX    = 7;
    localparam int FRAC_STEPS    = 1024;
    localparam int OCTAVE_OFFSET = 16;      // keeps the low nibble two's compl.
    localparam int N_DIRECTED    = 22;

    // Expected content of one result strobe.
    typedef struct packed {
        logic [OCT_W-1:0]  octave;
        logic [FRAC_W-1:0] fraction;
        logic [WORD_W-1:0] word;
    } t_pitch;

    // ------------------------------------------------------------------------
    // DUT signals; every input is known from time zero.
    // ------------------------------------------------------------------------
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    start         = 1'b0;
    logic                    busy;
    logic [RATE_W-1:0]       i_sample_rate = '0;
    logic [SCALE_W-1:0]      i_pitch_scale = '0;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [NAT_W-1:0]        i_cfg_data    = '0;
    logic                    o_valid;
    logic signed [OCT_W-1:0] o_octave;
    logic [FRAC_W-1:0]       o_fraction;
    logic [WORD_W-1:0]       o_pitch_word;

    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------------
    // Scoreboard: owns the native rate copy, the predictor and the queue of
    // pitch words still owed by the block.
    // ------------------------------------------------------------------------
    class pitch_scoreboard;
        logic [NAT_W-1:0] native_rate;
        t_pitch           owed_words[$];
        int unsigned      mismatches;

        function new();
            native_rate = NATIVE_RESET;
            mismatches  = 0;
        endfunction

        function void set_native(logic [NAT_W-1:0] rate);
            native_rate = rate;
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
            mismatches++;
        endtask

        // Ratio = rate * scale / (native << 16), normalized into -8..7 and
        // rounded to 1/1024 above 1.0.
        function t_pitch predict_pitch(logic [RATE_W-1:0] rate, logic [SCALE_W-1:0] scale);
            logic [63:0]       num;
            logic [63:0]       den;
            logic [63:0]       quo;
            int                oct;
            logic [FRAC_W-1:0] frac;
            logic [OCT_W-1:0]  oct_bits;
            t_pitch            p;
            oct  = 0;
            frac = '0;
            if (rate == '0 || scale == '0) begin
                return '0;
            end
            if (native_rate == '0) begin
                // unbounded ratio
                oct  = OCTAVE_MAX;
                frac = FRAC_MAX;
            end else begin
                num = 64'(rate) * 64'(scale);
                den = 64'(native_rate) << 16;
                while (num < den && oct > OCTAVE_MIN) begin
                    num = num << 1;
                    oct--;
                end
                // at octave 7 a ratio of 2.0 or more stays put and saturates
                while (num >= (den << 1) && oct < OCTAVE_MAX) begin
                    den = den << 1;
                    oct++;
                end
                if (num > den) begin
                    quo  = ((num - den) * 64'(FRAC_STEPS) + (den >> 1)) / den;
                    frac = (quo > 64'(FRAC_MAX)) ? FRAC_MAX : quo[FRAC_W-1:0];
                end
            end
            oct_bits   = OCT_W'(oct + OCTAVE_OFFSET);
            p.octave   = oct_bits;
            p.fraction = frac;
            p.word     = {oct_bits, 1'b0, frac};
            return p;
        endfunction

        function void note_request(logic [RATE_W-1:0] rate, logic [SCALE_W-1:0] scale);
            owed_words.push_back(predict_pitch(rate, scale));
        endfunction

        task check_result(logic [OCT_W-1:0] octave, logic [FRAC_W-1:0] fraction,
                          logic [WORD_W-1:0] word);
            t_pitch want;
            if (owed_words.size() == 0) begin
                report_mismatch("unexpected result, word", 32'(word), 32'hFFFF_FFFF);
            end else begin
                want = owed_words.pop_front();
                if (octave !== want.octave)
                    report_mismatch("octave", 32'(octave), 32'(want.octave));
                if (fraction !== want.fraction)
                    report_mismatch("fraction", 32'(fraction), 32'(want.fraction));
                if (word !== want.word)
                    report_mismatch("pitch word", 32'(word), 32'(want.word));
            end
        endtask
    endclass

    pitch_scoreboard sb;

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    pitch_octave_fraction_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_sample_rate (i_sample_rate),
        .i_pitch_scale (i_pitch_scale),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_octave      (o_octave),
        .o_fraction    (o_fraction),
        .o_pitch_word  (o_pitch_word)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Results live for one cycle only; sample each strobe at the edge that
    // closes it, before the block updates its outputs.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result(o_octave, o_fraction, o_pitch_word);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Called at a falling edge; return at a falling edge. start is
    // left high so a back-to-back request keeps it up without a glitch.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [RATE_W-1:0] rate,
                                input logic [SCALE_W-1:0] scale);
        start         <= 1'b1;
        i_sample_rate <= rate;
        i_pitch_scale <= scale;
        do @(posedge i_clk); while (busy);
        sb.note_request(rate, scale);
        @(negedge i_clk);
    endtask

    task automatic write_native_rate(input logic [NAT_W-1:0] rate);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rate;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_native(rate);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop start and wait until every owed pitch word has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // Random bit length so ratios land on every octave, not only at the top;
    // now and then a zero or an all-ones operand.
    function automatic logic [31:0] random_operand(int unsigned width);
        logic [31:0] full;
        logic [31:0] mask;
        full = (32'd1 << width) - 1;
        mask = (32'd1 << $urandom_range(1, width)) - 1;
        case ($urandom_range(0, 15))
            0: begin
                return '0;
            end
            1: begin
                return full;
            end
            default: begin
                return $urandom & mask;
            end
        endcase
    endfunction

    // Bursts of back-to-back requests separated by random gaps.
    task automatic run_random_requests(input int unsigned count);
        int unsigned burst_left;
        int unsigned gap;
        burst_left = $urandom_range(1, 24);
        for (int unsigned i = 0; i < count; i++) begin
            send_request(RATE_W'(random_operand(RATE_W)), SCALE_W'(random_operand(SCALE_W)));
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    start <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [RATE_W-1:0]  dir_rate  [N_DIRECTED];
        logic [SCALE_W-1:0] dir_scale [N_DIRECTED];
        logic [NAT_W-1:0]   native_plan [7];

        sb = new();

        // Directed requests, native rate at its reset value of 44100.
        // zero operands
        dir_rate[0]  = '0;        dir_scale[0]  = 24'h010000;
        dir_rate[1]  = 20'd44100; dir_scale[1]  = '0;
        dir_rate[2]  = '0;        dir_scale[2]  = '0;
        // largest ratio: saturates at octave 7
        dir_rate[3]  = '1;        dir_scale[3]  = '1;
        // tiny ratio: still below 1.0 at octave -8
        dir_rate[4]  = 20'd1;     dir_scale[4]  = 24'd1;
        // exact powers of two
        dir_rate[5]  = 20'd44100; dir_scale[5]  = 24'h010000;
        dir_rate[6]  = 20'd44100; dir_scale[6]  = 24'h020000;
        dir_rate[7]  = 20'd44100; dir_scale[7]  = 24'h008000;
        dir_rate[8]  = 20'd22050; dir_scale[8]  = 24'h010000;
        // just under 2.0: fraction rounds up to one and saturates
        dir_rate[9]  = 20'd44100; dir_scale[9]  = 24'h01FFFF;
        // mid fraction and a sliver above one that rounds down
        dir_rate[10] = 20'd44100; dir_scale[10] = 24'h018000;
        dir_rate[11] = 20'd44100; dir_scale[11] = 24'h010001;
        // top octave exactly, mid and saturated
        dir_rate[12] = 20'd44100; dir_scale[12] = 24'h800000;
        dir_rate[13] = 20'd44100; dir_scale[13] = 24'hC00000;
        dir_rate[14] = 20'd44100; dir_scale[14] = 24'hFFFFFF;
        // bottom octave exactly and just below it
        dir_rate[15] = 20'd44100; dir_scale[15] = 24'd256;
        dir_rate[16] = 20'd44100; dir_scale[16] = 24'd255;
        // lopsided operands and alternating bit patterns
        dir_rate[17] = 20'd1;     dir_scale[17] = '1;
        dir_rate[18] = '1;        dir_scale[18] = 24'd1;
        dir_rate[19] = 20'h80000; dir_scale[19] = 24'h800000;
        dir_rate[20] = 20'h55555; dir_scale[20] = 24'hAAAAAA;
        dir_rate[21] = 20'hAAAAA; dir_scale[21] = 24'h555555;

        // extremes, zero, common rates, two random ones
        native_plan[0] = 16'd1;
        native_plan[1] = 16'hFFFF;
        native_plan[2] = 16'd0;
        native_plan[3] = 16'd48000;
        native_plan[4] = 16'd22050;
        native_plan[5] = NAT_W'($urandom);
        native_plan[6] = NAT_W'(random_operand(NAT_W));

        // synchronous reset, once
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(dir_rate[i], dir_scale[i]);
        end
        drain_results();

        run_random_requests(ITEMS_PHASE);
        drain_results();

        // register writes only with the pipeline empty
        foreach (native_plan[p]) begin
            write_native_rate(native_plan[p]);
            run_random_requests(ITEMS_PHASE);
            drain_results();
        end

        // catch any stray strobe after the last owed word
        repeat (2 * LATENCY) @(negedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pof_pkg.sv
src/pof_norm.sv
src/pof_div.sv
src/pitch_octave_fraction_encoder.sv
tb/sv/pitch_octave_fraction_encoder_test.sv
